>>> hdl/rpip_pkg.sv
`default_nettype none
package rpip_pkg;

  localparam logic [7:0]  NUL_CHAR    = 8'h00;
  localparam logic [31:0] ERROR_VALUE = 32'hABF41C01;
  localparam logic [5:0]  RADIX_RESET = 6'd10;

  typedef enum logic [7:0] {
    PH_LEAD    = 8'b0000_0001,
    PH_MINUS   = 8'b0000_0010,
    PH_ZERO    = 8'b0000_0100,
    PH_X       = 8'b0000_1000,
    PH_DOLLAR  = 8'b0001_0000,
    PH_PERCENT = 8'b0010_0000,
    PH_DIGITS  = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] accum;
    logic        negative;
    logic [5:0]  radix;
    logic        digit_seen;
  } parse_state_t;

endpackage
`default_nettype wire

>>> hdl/rpip_step.sv
`default_nettype none
module rpip_step (
  input  rpip_pkg::parse_state_t st,
  input  logic [7:0]             ch,
  input  logic [5:0]             dflt_radix,
  output rpip_pkg::parse_state_t st_next,
  output logic [31:0]            res_value,
  output logic                   res_bad
);
  import rpip_pkg::*;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X_LO    = 8'h78;
  localparam logic [7:0] CH_X_UP    = 8'h58;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] NO_DIGIT   = 8'hFF;

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h57;
    end else begin
      d = NO_DIGIT;
    end
    return d;
  endfunction

  logic        at_lead;
  logic        reach_minus;
  logic        reach_zero;
  logic        reach_dollar;
  logic        reach_percent;
  logic [5:0]  radix_eff;
  logic [7:0]  dig;
  logic [31:0] prod;

  assign at_lead       = (st.phase == PH_LEAD);
  assign reach_minus   = at_lead || (st.phase == PH_MINUS);
  assign reach_zero    = reach_minus || (st.phase == PH_ZERO);
  // a failed '0' test skips the x test and lands on '$'
  assign reach_dollar  = reach_zero || (st.phase == PH_X) || (st.phase == PH_DOLLAR);
  assign reach_percent = reach_dollar || (st.phase == PH_PERCENT);
  assign radix_eff     = at_lead ? dflt_radix : st.radix;
  assign dig           = digit_of(ch);
  // only the low 32 bits survive the wrap
  assign prod          = st.accum * {26'd0, radix_eff};

  assign res_bad   = (st.phase == PH_ERROR) || !st.digit_seen;
  assign res_value = res_bad      ? ERROR_VALUE :
                     st.negative  ? (~st.accum + 32'd1) : st.accum;

  always_comb begin
    st_next = st;
    if (ch == NUL_CHAR) begin
      st_next.phase      = PH_LEAD;
      st_next.accum      = 32'd0;
      st_next.negative   = 1'b0;
      st_next.radix      = dflt_radix;
      st_next.digit_seen = 1'b0;
    end else if (st.phase == PH_ERROR || (at_lead && ch == CH_SPACE)) begin
      st_next = st;
    end else begin
      st_next.radix = radix_eff;
      if (at_lead && ch == CH_PLUS) begin
        st_next.phase = PH_MINUS;
      end else if (reach_minus && ch == CH_MINUS) begin
        st_next.negative = 1'b1;
        st_next.phase    = PH_ZERO;
      end else if (reach_zero && ch == CH_ZERO) begin
        st_next.digit_seen = 1'b1;
        st_next.radix      = 6'd8;
        st_next.phase      = PH_X;
      end else if (st.phase == PH_X && (ch == CH_X_LO || ch == CH_X_UP)) begin
        st_next.radix = 6'd16;
        st_next.phase = PH_DOLLAR;
      end else if (reach_dollar && ch == CH_DOLLAR) begin
        st_next.radix = 6'd16;
        st_next.phase = PH_PERCENT;
      end else if (reach_percent && ch == CH_PERCENT) begin
        st_next.radix = 6'd2;
        st_next.phase = PH_DIGITS;
      end else begin
        st_next.phase = PH_DIGITS;
        if (ch != CH_SPACE) begin
          if (dig >= {2'b00, radix_eff}) begin
            st_next.phase = PH_ERROR;
          end else begin
            st_next.accum      = prod + {24'd0, dig};
            st_next.digit_seen = 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/radix_prefixed_integer_parser.sv
// A NUL beat moves from the character register into the result register, which holds its result beat.
// Throughput: one character per cycle; the character register feeds one
// multiply-accumulate (32 x 6 bits) into the parse state each cycle.
// Only a NUL waits, and only while the result register is full and stalled.
// Synchronous reset: parser back to leading-space phase, default radix 10,
// no result pending.
`default_nettype none
module radix_prefixed_integer_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [7:0]         ch,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] value,
  output logic               bad,
  input  logic               default_radix_we,
  input  logic [5:0]         default_radix
);
  import rpip_pkg::*;

  logic         q_valid;
  logic [7:0]   q_ch;
  logic [5:0]   dflt_radix;
  parse_state_t st;
  parse_state_t st_next;
  logic [31:0]  res_value;
  logic         res_bad;
  logic         out_free;
  logic         advance;

  rpip_step u_step (
    .st         (st),
    .ch         (q_ch),
    .dflt_radix (dflt_radix),
    .st_next    (st_next),
    .res_value  (res_value),
    .res_bad    (res_bad)
  );

  assign out_free   = !result_valid || !result_stall;
  assign advance    = q_valid && ((q_ch != NUL_CHAR) || out_free);
  assign item_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_radix <= RADIX_RESET;
    end else if (default_radix_we) begin
      dflt_radix <= default_radix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!item_stall) begin
      q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      q_ch <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_LEAD;
      st.accum      <= 32'd0;
      st.negative   <= 1'b0;
      st.radix      <= RADIX_RESET;
      st.digit_seen <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && q_ch == NUL_CHAR) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_ch == NUL_CHAR) begin
      value <= res_value;
      bad   <= res_bad;
    end
  end

`ifndef NO_ASSERTIONS
  // a fresh result beat only follows a NUL leaving the character register
  a_result_from_nul: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(advance && q_ch == NUL_CHAR))
    else $error("result beat without a NUL");

  a_clear_after_nul: assert property (@(posedge clk) disable iff (rst)
    (advance && q_ch == NUL_CHAR) |=>
      (st.phase == PH_LEAD && st.accum == 32'd0 && !st.negative && !st.digit_seen))
    else $error("parse state not cleared after NUL");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (q_valid && q_ch == NUL_CHAR && result_valid && result_stall))
    else $error("input stalled without a blocked NUL");

  a_bad_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad) |-> (value == ERROR_VALUE))
    else $error("rejected string without error value");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpip_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int CHARS_PER_SETTING = 86;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] NOT_DIGIT  = 8'hFF;

  typedef struct {
    logic signed [31:0] value;
    logic               bad;
  } parse_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [7:0]         ch = 8'h00;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [31:0] value;
  logic               bad;
  logic               default_radix_we = 1'b0;
  logic [5:0]         default_radix = 6'd0;

  radix_prefixed_integer_parser uut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .ch               (ch),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .value            (value),
    .bad              (bad),
    .default_radix_we (default_radix_we),
    .default_radix    (default_radix)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser mirror
  phase_t     ph = PH_LEAD;
  logic [31:0] acc = '0;
  logic        neg = 1'b0;
  logic [5:0]  radix = RADIX_RESET;
  logic        seen = 1'b0;
  logic [5:0]  cfg_radix = RADIX_RESET;

  parse_result_t parsed_q[$];
  logic [7:0]    char_q[$];
  int chars_pending = 0;
  int chars_queued = 0;
  int strings_queued = 0;
  int results_seen = 0;
  int rejects_seen = 0;
  int mismatches = 0;
  int settings_used = 0;
  bit idle_on = 1'b1;

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h5A) return c - 8'h41 + 8'd10;
    if (c >= 8'h61 && c <= 8'h7A) return c - 8'h61 + 8'd10;
    return NOT_DIGIT;
  endfunction

  task automatic expect_result(input logic [31:0] v, input logic b);
    parse_result_t r;
    r.value = v;
    r.bad = b;
    parsed_q.push_back(r);
  endtask

  task automatic parse_char(input logic [7:0] c);
    phase_t p;
    logic [7:0] d;
    p = ph;
    if (c == NUL_CHAR) begin
      if (p == PH_ERROR || !seen) expect_result(ERROR_VALUE, 1'b1);
      else expect_result(neg ? 32'd0 - acc : acc, 1'b0);
      ph = PH_LEAD;
      acc = '0;
      neg = 1'b0;
      radix = cfg_radix;
      seen = 1'b0;
      return;
    end
    if (p == PH_ERROR) return;
    // each prefix test falls through to the next one when it does not match
    if (p == PH_LEAD) begin
      if (c == CH_SPACE) return;
      radix = cfg_radix;
      if (c == CH_PLUS) begin
        ph = PH_MINUS;
        return;
      end
      p = PH_MINUS;
    end
    if (p == PH_MINUS) begin
      if (c == CH_MINUS) begin
        neg = 1'b1;
        ph = PH_ZERO;
        return;
      end
      p = PH_ZERO;
    end
    if (p == PH_ZERO) begin
      if (c == CH_ZERO) begin
        seen = 1'b1;
        radix = 6'd8;
        ph = PH_X;
        return;
      end
      p = PH_DOLLAR;
    end
    if (p == PH_X) begin
      if (c == CH_LOWER_X || c == CH_UPPER_X) begin
        radix = 6'd16;
        ph = PH_DOLLAR;
        return;
      end
      p = PH_DOLLAR;
    end
    if (p == PH_DOLLAR) begin
      if (c == CH_DOLLAR) begin
        radix = 6'd16;
        ph = PH_PERCENT;
        return;
      end
      p = PH_PERCENT;
    end
    if (p == PH_PERCENT) begin
      if (c == CH_PERCENT) begin
        radix = 6'd2;
        ph = PH_DIGITS;
        return;
      end
    end
    ph = PH_DIGITS;
    if (c == CH_SPACE) return;
    d = digit_of(c);
    if (d >= {2'b00, radix}) begin
      ph = PH_ERROR;
      return;
    end
    acc = acc * {26'd0, radix} + {24'd0, d};
    seen = 1'b1;
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_idle();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // character driver
  int char_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        parse_char(ch);
        chars_pending--;
      end
      if (!item_valid || !item_stall) begin
        if (char_gap != 0) begin
          char_gap--;
          item_valid <= 1'b0;
        end else if (char_q.size() != 0) begin
          ch <= char_q.pop_front();
          item_valid <= 1'b1;
          char_gap = pick_idle();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int stall_left = 0;
  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (bad === 1'b1) rejects_seen++;
        if (parsed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat value=%0d bad=%b", $realtime, value, bad);
        end else begin
          want = parsed_q.pop_front();
          if (value !== want.value || bad !== want.bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: expected value=%0d bad=%b, got value=%0d bad=%b",
                       $realtime, results_seen, want.value, want.bad, value, bad);
          end
        end
      end
      if (stall_left == 0) stall_left = pick_idle();
      if (stall_left != 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles without any beat on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $realtime, QUIET_LIMIT, parsed_q.size());
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  task automatic add_char(input logic [7:0] c);
    char_q.push_back(c);
    chars_pending++;
    chars_queued++;
    if (c == NUL_CHAR) strings_queued++;
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_char(s[i]);
    add_char(NUL_CHAR);
  endtask

  function automatic logic [7:0] digit_char(input int dv);
    if (dv < 10) return CH_ZERO + dv[7:0];
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + dv[7:0] - 8'd10;
  endfunction

  // sign, prefixes and digits in the order the parser takes them;
  // broken strings get one random byte among the digits
  task automatic add_number(input bit broken);
    int r;
    int n;
    int hit;
    bit zero;
    r = int'(cfg_radix);
    repeat ($urandom_range(0, 2)) add_char(CH_SPACE);
    case ($urandom_range(0, 3))
      1: add_char(CH_PLUS);
      2: add_char(CH_MINUS);
      3: begin
        add_char(CH_PLUS);
        add_char(CH_MINUS);
      end
      default: ;
    endcase
    zero = ($urandom_range(0, 2) == 0);
    if (zero) begin
      add_char(CH_ZERO);
      r = 8;
      if ($urandom_range(0, 1)) begin
        add_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
        r = 16;
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      add_char(CH_DOLLAR);
      r = 16;
    end
    if ($urandom_range(0, 4) == 0) begin
      add_char(CH_PERCENT);
      r = 2;
    end
    n = $urandom_range(zero ? 0 : 1, 12);
    hit = broken ? $urandom_range(0, n) : -1;
    for (int i = 0; i <= n; i++) begin
      if (i == hit) add_char(8'($urandom_range(1, 255)));
      if (i == n) break;
      if ($urandom_range(0, 7) == 0) add_char(CH_SPACE);
      if (r == 0) add_char(8'($urandom_range(1, 255)));
      else add_char(digit_char($urandom_range(0, (r > 36 ? 36 : r) - 1)));
    end
    add_char(NUL_CHAR);
  endtask

  task automatic add_noise();
    repeat ($urandom_range(0, 6)) add_char(8'($urandom_range(1, 255)));
    add_char(NUL_CHAR);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (chars_pending != 0 || parsed_q.size() != 0);
  endtask

  task automatic write_radix(input logic [5:0] r);
    @(posedge clk);
    default_radix_we <= 1'b1;
    default_radix <= r;
    cfg_radix = r;
    @(posedge clk);
    default_radix_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [5:0] settings[$];
    int phase_start;
    int roll;
    settings = '{6'd10, 6'd16, 6'd2, 6'd36, 6'd7, 6'd0, 6'd1, 6'd37, 6'd63, 6'd0};
    settings[9] = 6'($urandom_range(2, 36));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed strings at the reset radix
    add_text("");
    add_text(" +-");
    add_text(" -0xA");
    add_text("$g");
    add_text("%1 01");
    add_char(8'hFF);
    add_char(NUL_CHAR);
    add_text("4294967297");
    wait_drained();
    repeat (4) @(posedge clk);

    foreach (settings[k]) begin
      write_radix(settings[k]);
      idle_on = (k % 4 != 1);
      phase_start = chars_queued;
      while (chars_queued - phase_start < CHARS_PER_SETTING) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) add_number(1'b0);
        else if (roll < 85) add_number(1'b1);
        else add_noise();
      end
      // leave a string open across the next register write
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 2)) add_char(CH_SPACE);
        if ($urandom_range(0, 1)) add_char(CH_MINUS);
      end
      wait_drained();
      repeat (4) @(posedge clk);
    end
    add_text("1");

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d characters in %0d strings over %0d radix settings", chars_queued,
             strings_queued, settings_used);
    $display("%0d results checked, %0d rejected, %0d mismatches", results_seen,
             rejects_seen, mismatches);
    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hdl/rpip_pkg.sv
hdl/rpip_step.sv
hdl/radix_prefixed_integer_parser.sv
tb/testbench.sv
